// ----- rtl/mted_pkg.sv -----
// ============================================================================
// mted_pkg
// Shared types and constants of the multitap echo delay.
// ============================================================================
package mted_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int DECAY_W   = 10;
    localparam int SPACING_W = 17;
    localparam int TAPCNT_W  = 5;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_DECAY     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SPACING   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TAP_COUNT = 2'd2;

    localparam logic [DECAY_W-1:0]   DECAY_RESET     = 10'd550;
    localparam logic [SPACING_W-1:0] SPACING_RESET   = 17'd11300;
    localparam logic [TAPCNT_W-1:0]  TAP_COUNT_RESET = 5'd8;
    localparam logic [DECAY_W-1:0]   DECAY_MAX       = 10'd1000;

    // Gain is round(decay * 4096 / 125); the quotient uses a reciprocal
    // multiply followed by one correction step.
    localparam int GAIN_NUM_W = 22;
    localparam logic [GAIN_NUM_W-1:0] GAIN_ROUND = 22'd62;
    localparam int RECIP_W = 23;
    localparam logic [RECIP_W-1:0] GAIN_RECIP = 23'd4294967;
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_PROD_W = GAIN_NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] GAIN_DIVISOR = 23'd125;
    localparam int GAIN_W = 16;

    typedef struct packed {
        logic accept;
        logic gain;
        logic load;
        logic issue;
        logic commit;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic taps_zero;
        logic last_tap;
        logic out_free;
    } ctrl_status_t;

endpackage

// ----- rtl/multitap_echo_delay.sv -----
// ============================================================================
// multitap_echo_delay
// Multitap feedforward echo: per channel sample history, up to MAX_TAPS
// decaying echo taps summed with the dry sample.
// ============================================================================
//
// Channel   Handshake                   Content
// s_axis    tvalid / tready             tdata: sample_in; tuser: channel
// m_axis    tvalid / tready             tdata: sample_out
// cfg       cfg_we (no wait)            cfg_addr selects register, cfg_wdata
//
// With n = min(tap_count, MAX_TAPS), an accepted word passes the gain setup,
// the load, n tap issues, the history write, a drain step and the output
// load, and the next word is accepted only after that; the single history read
// port sets one tap per cycle. After reset the history reads as empty at once,
// with no clearing pass. A stalled output holds its word while the next input
// word is accepted and processed; the block then waits in its last step.
//
module multitap_echo_delay #(
    parameter int HISTORY_DEPTH = 131072,
    parameter int CHANNELS      = 2,
    parameter int MAX_TAPS      = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // [15:0] sample_in
    input  logic [0:0]                          s_axis_tuser,  // [0] channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [15:0]                         m_axis_tdata,  // [15:0] sample_out
    input  logic                                cfg_we,
    input  logic [mted_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mted_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import mted_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic signed [SAMPLE_W-1:0] sample_out;

    mted_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mted_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .CHANNELS      (CHANNELS),
        .MAX_TAPS      (MAX_TAPS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .sample_in  ($signed(s_axis_tdata)),
        .channel    (s_axis_tuser[0]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .sample_out (sample_out),
        .cmd        (cmd),
        .status     (status)
    );

    assign m_axis_tdata = sample_out;

endmodule

// ----- rtl/mted_ram.sv -----
// ============================================================================
// mted_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module mted_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mted_ctrl.sv -----
// ============================================================================
// mted_ctrl
// Sequencer of the echo delay: accepts a word, runs the gain setup, the tap
// reads, the history write and the output load.
// ============================================================================
module mted_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mted_pkg::ctrl_status_t status,
    output mted_pkg::ctrl_cmd_t   cmd
);
    import mted_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_GAIN   = 7'b0000010,
        S_LOAD   = 7'b0000100,
        S_ISSUE  = 7'b0001000,
        S_COMMIT = 7'b0010000,
        S_DRAIN  = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_GAIN;
                end
            end
            S_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = status.taps_zero ? S_COMMIT : S_ISSUE;
            end
            S_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (status.last_tap)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/mted_datapath.sv -----
// ============================================================================
// mted_datapath
// Configuration registers, per-channel write positions and fill counts, the
// history memory, the tap read and multiply-accumulate pipeline and the
// output register.
// ============================================================================
module mted_datapath #(
    parameter int HISTORY_DEPTH = 131072,
    parameter int CHANNELS      = 2,
    parameter int MAX_TAPS      = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mted_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mted_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic signed [mted_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                              channel,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [mted_pkg::SAMPLE_W-1:0] sample_out,
    input  mted_pkg::ctrl_cmd_t               cmd,
    output mted_pkg::ctrl_status_t            status
);
    import mted_pkg::*;

    localparam int POS_W  = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = POS_W + 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TW     = $clog2(MAX_TAPS + 1);
    localparam int CNT_W  = (TW > TAPCNT_W) ? TW : TAPCNT_W;
    localparam int DW     = SPACING_W + TW;
    localparam int CMP_W  = (DW > FILL_W) ? DW : FILL_W;
    localparam int SUM_W  = SAMPLE_W + 1 + TW;
    localparam int Y_W    = SUM_W + 2;
    localparam int RAM_DEPTH = CHANNELS * (2 ** POS_W);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;

    localparam logic [FILL_W-1:0] DEPTH_C     = FILL_W'(HISTORY_DEPTH);
    localparam logic [CNT_W-1:0]  MAX_TAPS_C  = CNT_W'(MAX_TAPS);
    localparam logic signed [Y_W-1:0] SAT_HI  = Y_W'(32767);
    localparam logic signed [Y_W-1:0] SAT_LO  = Y_W'(-32768);

    // Configuration and history bookkeeping.
    logic [DECAY_W-1:0]   decay_reg;
    logic [SPACING_W-1:0] spacing_reg;
    logic [TAPCNT_W-1:0]  tap_count_reg;
    logic [POS_W-1:0]     wp_reg   [CHANNELS];
    logic [FILL_W-1:0]    fill_reg [CHANNELS];
    logic                 hist_clear;

    // Item payload.
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [CH_W-1:0]            ch_reg;
    logic [CH_W-1:0]            ch_next;

    // Gain setup.
    logic [DECAY_W-1:0]      dec_clamp;
    logic [GAIN_NUM_W-1:0]   gain_num;
    logic [GAIN_NUM_W-1:0]   gain_num_reg;
    logic [RECIP_PROD_W-1:0] recip_prod_reg;
    logic [GAIN_W-1:0]       gain_q0;
    logic [RECIP_W-1:0]      gain_rem;
    logic [GAIN_W-1:0]       gain_next;
    logic [GAIN_W-1:0]       gain_reg;

    // Tap issue stage.
    logic [TW-1:0]     taps_eff;
    logic [CNT_W-1:0]  tap_count_ext;
    logic [TW-1:0]     k_reg;
    logic [DW-1:0]     dist_reg;
    logic [GAIN_W-1:0] weight_reg;
    logic [GAIN_W-1:0] weight_next;
    logic [POS_W-1:0]  wp_cur;
    logic [FILL_W-1:0] fill_cur;
    logic              tap_valid;
    logic [FILL_W-1:0] dist_lo;
    logic [FILL_W-1:0] wp_ext;
    logic [FILL_W-1:0] pos_wide;
    logic [POS_W-1:0]  rd_pos;

    // Read, multiply and accumulate stages.
    logic                     v1_reg;
    logic                     v2_reg;
    logic [GAIN_W-1:0]        w1_reg;
    logic [SAMPLE_W-1:0]      ram_rdata;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_bias;
    logic signed [PROD_W-1:0] tap_val;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;

    // Output.
    logic signed [SAMPLE_W:0] x_ext;
    logic signed [SAMPLE_W:0] x_half;
    logic signed [SUM_W:0]    s_ext;
    logic signed [SUM_W:0]    s_half;
    logic signed [Y_W-1:0]    y_full;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic signed [SAMPLE_W-1:0] out_data_reg;
    logic                       out_valid_reg;

    logic [POS_W-1:0]  wp_inc;
    logic [RAM_AW-1:0] ram_waddr;
    logic [RAM_AW-1:0] ram_raddr;

    assign hist_clear = cfg_we && ((cfg_addr == REG_DECAY) || (cfg_addr == REG_SPACING));
    assign ch_next    = (CHANNELS > 1) ? CH_W'(channel) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg     <= DECAY_RESET;
            spacing_reg   <= SPACING_RESET;
            tap_count_reg <= TAP_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DECAY:     decay_reg     <= cfg_wdata[DECAY_W-1:0];
                REG_SPACING:   spacing_reg   <= cfg_wdata[SPACING_W-1:0];
                REG_TAP_COUNT: tap_count_reg <= cfg_wdata[TAPCNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Gain: round(decay * 32768 / 1000) as a reciprocal multiply and fixup.
    assign dec_clamp = (decay_reg > DECAY_MAX) ? DECAY_MAX : decay_reg;
    assign gain_num  = {dec_clamp, 12'd0} + GAIN_ROUND;
    assign gain_q0   = recip_prod_reg[RECIP_SHIFT +: GAIN_W];
    assign gain_rem  = RECIP_W'(gain_num_reg) - RECIP_W'(RECIP_W'(gain_q0) * GAIN_DIVISOR);
    assign gain_next = (gain_rem >= GAIN_DIVISOR) ? gain_q0 + 1'b1 : gain_q0;

    assign tap_count_ext = CNT_W'(tap_count_reg);
    assign taps_eff = TW'((tap_count_ext > MAX_TAPS_C) ? MAX_TAPS_C : tap_count_ext);

    assign wp_cur   = wp_reg[ch_reg];
    assign fill_cur = fill_reg[ch_reg];
    assign tap_valid = (dist_reg != '0) && (CMP_W'(dist_reg) <= CMP_W'(fill_cur));
    assign dist_lo  = dist_reg[FILL_W-1:0];
    assign wp_ext   = {1'b0, wp_cur};
    assign pos_wide = (wp_ext >= dist_lo) ? wp_ext - dist_lo : wp_ext + DEPTH_C - dist_lo;
    assign rd_pos   = pos_wide[POS_W-1:0];
    assign weight_next = GAIN_W'((32'(weight_reg) * 32'(gain_reg)) >> 15);

    assign ram_raddr = RAM_AW'({ch_reg, rd_pos});
    assign ram_waddr = RAM_AW'({ch_reg, wp_cur});
    assign wp_inc    = (FILL_W'(wp_cur) + 1'b1 == DEPTH_C) ? '0 : wp_cur + 1'b1;

    mted_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RAM_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (ram_waddr),
        .wdata (x_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign prod_next = $signed(ram_rdata) * $signed({1'b0, w1_reg});
    assign prod_bias = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'(32767) : PROD_W'(0));
    assign tap_val   = prod_bias >>> 15;
    assign sum_next  = v2_reg ? sum_reg + SUM_W'(tap_val) : sum_reg;

    assign x_ext  = {x_reg[SAMPLE_W-1], x_reg};
    assign x_half = (x_ext + $signed({{SAMPLE_W{1'b0}}, x_reg[SAMPLE_W-1]})) >>> 1;
    assign s_ext  = {sum_reg[SUM_W-1], sum_reg};
    assign s_half = (s_ext + $signed({{SUM_W{1'b0}}, sum_reg[SUM_W-1]})) >>> 1;
    assign y_full = Y_W'(x_half) + Y_W'(s_half);
    assign y_sat  = (y_full > SAT_HI) ? SAMPLE_W'(SAT_HI) :
                    (y_full < SAT_LO) ? SAMPLE_W'(SAT_LO) : y_full[SAMPLE_W-1:0];

    // Control state: positions, fill counts, pipeline valids, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                wp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
            k_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (hist_clear)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    wp_reg[i]   <= '0;
                    fill_reg[i] <= '0;
                end
            end
            else if (cmd.commit)
            begin
                wp_reg[ch_reg] <= wp_inc;
                if (fill_cur < DEPTH_C)
                begin
                    fill_reg[ch_reg] <= fill_cur + 1'b1;
                end
            end
            if (cmd.load)
            begin
                k_reg <= '0;
            end
            else if (cmd.issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            v1_reg <= cmd.issue && tap_valid;
            v2_reg <= v1_reg;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg  <= sample_in;
            ch_reg <= ch_next;
        end
        if (cmd.gain)
        begin
            gain_num_reg   <= gain_num;
            recip_prod_reg <= RECIP_PROD_W'(gain_num) * RECIP_PROD_W'(GAIN_RECIP);
        end
        if (cmd.load)
        begin
            gain_reg   <= gain_next;
            weight_reg <= gain_next;
            dist_reg   <= DW'(spacing_reg);
            sum_reg    <= '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                weight_reg <= weight_next;
                dist_reg   <= dist_reg + DW'(spacing_reg);
            end
            sum_reg <= sum_next;
        end
        w1_reg   <= weight_reg;
        prod_reg <= prod_next;
        if (cmd.finish)
        begin
            out_data_reg <= y_sat;
        end
    end

    assign status.taps_zero = (tap_count_reg == '0);
    assign status.last_tap  = (k_reg == taps_eff - 1'b1);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

endmodule
